@@ design/smeu_pkg.sv @@
// Shared types and constants for the stack machine execute unit.
// No dependencies; used by the controller, datapath and top level.
package smeu_pkg;

    localparam int OP_W    = 5;
    localparam int WORD_W  = 32;
    localparam int TGT_W   = 12;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 7;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_MUL = 5'd3, OP_DIV = 5'd4,
        OP_EQ = 5'd5, OP_NE = 5'd6, OP_NOT = 5'd7, OP_GT = 5'd8, OP_LT = 5'd9,
        OP_GE = 5'd10, OP_LE = 5'd11, OP_PICK = 5'd12, OP_BRZ = 5'd13,
        OP_JMP = 5'd14, OP_MGET = 5'd15, OP_MSET = 5'd16, OP_PRINT = 5'd17,
        OP_PRINTLN = 5'd18
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE = 3'd0, ERR_OVERFLOW = 3'd1, ERR_UNDERFLOW = 3'd2,
        ERR_STORE = 3'd3, ERR_DIVZERO = 3'd4
    } err_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;   // latch input item, issue reads of top and below-top
        logic fetch;     // latch read data (and pick / store operands)
        logic pick_rd;   // issue read of picked entry
        logic div_start; // launch divider
        logic finish;    // compute result, update state, load output
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_div;
        logic is_pick_ok;
        logic div_done;
    } sts_t;

endpackage

@@ design/smeu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smeu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ design/smeu_div.sv @@
// Iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on smeu_pkg.
module smeu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [smeu_pkg::WORD_W-1:0] num,
    input  logic [smeu_pkg::WORD_W-1:0] den,
    output logic                        done,
    output logic [smeu_pkg::WORD_W-1:0] quot
);
    localparam int W = smeu_pkg::WORD_W;

    logic [W-1:0]         rem_reg, rem_next;
    logic [W-1:0]         q_reg, q_next;
    logic [W-1:0]         d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [$clog2(W):0]   cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [W:0]           trial;
    logic [W-1:0]         shifted;

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-2:0], q_reg[W-1]};
        trial     = {1'b0, shifted} - {1'b0, d_reg};
        if (start) begin
            rem_next  = '0;
            q_next    = num[W-1] ? (~num + 1'b1) : num;
            d_next    = den[W-1] ? (~den + 1'b1) : den;
            neg_next  = num[W-1] ^ den[W-1];
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // rem stays below 2^31 even with a 2^31 divisor; shift keeps W bits since rem < d
            if (!trial[W] || rem_reg[W-1]) begin
                rem_next = shifted - d_reg;
                q_next   = {q_reg[W-2:0], 1'b1};
            end else begin
                rem_next = shifted;
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(W)+1)'(W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? (~q_reg + 1'b1) : q_reg;
endmodule

@@ design/smeu_ctrl.sv @@
// Sequencing state machine of the execute unit.
// Depends on smeu_pkg.
module smeu_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_xfer,
    input  logic            out_free,
    input  smeu_pkg::sts_t  sts,
    output logic            in_ready,
    output smeu_pkg::cmd_t  cmd
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_READ = 6'b000010, S_DECIDE = 6'b000100,
        S_PICK = 6'b001000, S_DIV  = 6'b010000, S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_xfer) begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ: begin
                cmd.fetch  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else if (sts.is_pick_ok) begin
                    cmd.pick_rd = 1'b1;
                    state_next  = S_PICK;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_PICK: state_next = S_DONE;
            S_DIV: if (sts.div_done) begin
                state_next = S_DONE;
            end
            S_DONE: if (out_free) begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == S_READ)
        else $error("capture did not advance to read");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> state_reg == S_IDLE)
        else $error("finish did not return to idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.finish, cmd.div_start, cmd.pick_rd, cmd.fetch}))
        else $error("overlapping commands");
endmodule

@@ design/smeu_dp.sv @@
// Datapath: operand stack RAM, word store, ALU, divider and result register.
// Depends on smeu_pkg, smeu_ram and smeu_div.
module smeu_dp #(
    parameter int STACK_DEPTH  = 64,
    parameter int STORE_DEPTH  = 8,
    parameter int PROGRAM_SPAN = 4096
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  smeu_pkg::cmd_t               cmd,
    output smeu_pkg::sts_t               sts,
    input  logic [smeu_pkg::OP_W-1:0]    in_op,
    input  logic [smeu_pkg::WORD_W-1:0]  in_imm,
    input  logic [smeu_pkg::TGT_W-1:0]   in_tgt,
    input  logic                         out_taken,
    output logic                         out_valid,
    output logic                         o_print_valid,
    output logic [smeu_pkg::WORD_W-1:0]  o_print_value,
    output logic                         o_newline,
    output logic                         o_jump_taken,
    output logic [smeu_pkg::TGT_W-1:0]   o_jump_index,
    output logic [smeu_pkg::ERR_W-1:0]   o_error,
    output logic [smeu_pkg::DEPTH_W-1:0] o_depth_now
);
    localparam int W   = smeu_pkg::WORD_W;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STORE_DEPTH);
    localparam int PW  = $clog2(PROGRAM_SPAN);

    logic [CW-1:0]              cnt_reg;
    logic [smeu_pkg::OP_W-1:0]  op_reg;
    logic [W-1:0]               imm_reg, a_reg, b_reg, pick_val, res;
    logic [smeu_pkg::TGT_W-1:0] tgt_reg;
    logic [W-1:0]               store_reg [STORE_DEPTH];
    logic                       ovalid_reg;
    logic [W-1:0]               rd_a, rd_b;
    logic [AW-1:0]              ra_a, ra_b, wa;
    logic                       we;
    logic [W-1:0]               wd;
    logic                       div_done;
    logic [W-1:0]               quot;
    logic [W-1:0]               mul_reg;
    logic                       pick_pend_reg;

    // Issue reads of top and below-top on capture, of the picked entry later.
    always_comb begin
        ra_a = AW'(cnt_reg - 1'b1);
        ra_b = AW'(cnt_reg - 2'd2);
        if (cmd.pick_rd) begin
            ra_b = AW'(cnt_reg - CW'(2) - CW'(a_reg));
        end
    end

    smeu_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram_a (
        .aclk, .we, .waddr(wa), .wdata(wd), .raddr(ra_a), .rdata(rd_a));
    smeu_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram_b (
        .aclk, .we, .waddr(wa), .wdata(wd), .raddr(ra_b), .rdata(rd_b));

    smeu_div u_div (.aclk, .aresetn, .start(cmd.div_start), .num(b_reg), .den(a_reg),
        .done(div_done), .quot(quot));

    logic need2, need1, under, pick_bad, idx_bad_a, idx_bad_b, lt_ab, lt_ba;
    smeu_pkg::op_t opc;
    assign opc = smeu_pkg::op_t'(op_reg);

    always_comb begin
        need2 = 1'b0;
        need1 = 1'b0;
        case (opc)
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
            smeu_pkg::OP_EQ, smeu_pkg::OP_NE, smeu_pkg::OP_GT, smeu_pkg::OP_LT,
            smeu_pkg::OP_GE, smeu_pkg::OP_LE, smeu_pkg::OP_PICK,
            smeu_pkg::OP_MSET: need2 = 1'b1;
            smeu_pkg::OP_NOT, smeu_pkg::OP_BRZ, smeu_pkg::OP_MGET, smeu_pkg::OP_PRINT,
            smeu_pkg::OP_PRINTLN: need1 = 1'b1;
            default: ;
        endcase
        under     = (need2 && cnt_reg < CW'(2)) || (need1 && cnt_reg == '0);
        pick_bad  = a_reg[W-1] || ({1'b0, a_reg} > {{(W+1-CW){1'b0}}, CW'(cnt_reg - CW'(2))});
        idx_bad_a = a_reg >= W'(STORE_DEPTH);
        idx_bad_b = b_reg >= W'(STORE_DEPTH);
        lt_ab     = $signed(a_reg) < $signed(b_reg);
        lt_ba     = $signed(b_reg) < $signed(a_reg);
    end

    assign sts.is_div     = (opc == smeu_pkg::OP_DIV) && !under && a_reg != '0;
    assign sts.is_pick_ok = (opc == smeu_pkg::OP_PICK) && !under && !pick_bad;
    assign sts.div_done   = div_done;

    // Picked entry arrives on the read port in the cycle after its address.
    always_ff @(posedge aclk) begin
        pick_pend_reg <= cmd.pick_rd;
        if (pick_pend_reg) begin
            pick_val <= rd_b;
        end
    end

    // Execute and commit on finish.
    logic [CW-1:0] cnt_next;
    logic [smeu_pkg::ERR_W-1:0] err;
    logic pv, nl, jt, st_we;
    always_comb begin
        cnt_next = cnt_reg;
        err      = smeu_pkg::ERR_NONE;
        pv = 1'b0; nl = 1'b0; jt = 1'b0; st_we = 1'b0;
        res = '0;
        we  = 1'b0;
        wa  = AW'(cnt_reg - 1'b1);
        case (opc)
            smeu_pkg::OP_ADD:  res = b_reg + a_reg;
            smeu_pkg::OP_SUB:  res = b_reg - a_reg;
            smeu_pkg::OP_MUL:  res = mul_reg;
            smeu_pkg::OP_DIV:  res = quot;
            smeu_pkg::OP_EQ:   res = W'(b_reg == a_reg);
            smeu_pkg::OP_NE:   res = W'(b_reg != a_reg);
            smeu_pkg::OP_GT:   res = W'(lt_ab);
            smeu_pkg::OP_LT:   res = W'(lt_ba);
            smeu_pkg::OP_GE:   res = W'(!lt_ba);
            smeu_pkg::OP_LE:   res = W'(!lt_ab);
            default:           res = '0;
        endcase
        if (under) begin
            err = smeu_pkg::ERR_UNDERFLOW;
        end else begin
            case (opc)
                smeu_pkg::OP_PUSH: begin
                    if (cnt_reg == CW'(STACK_DEPTH)) begin
                        err = smeu_pkg::ERR_OVERFLOW;
                    end else begin
                        we = 1'b1; wa = AW'(cnt_reg); res = imm_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
                smeu_pkg::OP_EQ, smeu_pkg::OP_NE, smeu_pkg::OP_GT, smeu_pkg::OP_LT,
                smeu_pkg::OP_GE, smeu_pkg::OP_LE: begin
                    if (opc == smeu_pkg::OP_DIV && a_reg == '0) begin
                        err = smeu_pkg::ERR_DIVZERO;
                    end else begin
                        we = 1'b1; wa = AW'(cnt_reg - CW'(2));
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                smeu_pkg::OP_NOT: begin
                    we = 1'b1; res = W'(a_reg == '0);
                end
                smeu_pkg::OP_PICK: begin
                    if (pick_bad) begin
                        err = smeu_pkg::ERR_UNDERFLOW;
                    end else begin
                        we = 1'b1; res = pick_val;
                    end
                end
                smeu_pkg::OP_BRZ: begin
                    cnt_next = cnt_reg - 1'b1;
                    jt = (a_reg == '0);
                end
                smeu_pkg::OP_JMP: jt = 1'b1;
                smeu_pkg::OP_MGET: begin
                    if (idx_bad_a) begin
                        err = smeu_pkg::ERR_STORE;
                    end else begin
                        we = 1'b1; res = store_reg[a_reg[SAW-1:0]];
                    end
                end
                smeu_pkg::OP_MSET: begin
                    if (idx_bad_b) begin
                        err = smeu_pkg::ERR_STORE;
                    end else begin
                        st_we = 1'b1; cnt_next = cnt_reg - CW'(2);
                    end
                end
                smeu_pkg::OP_PRINT, smeu_pkg::OP_PRINTLN: begin
                    pv = 1'b1; nl = (opc == smeu_pkg::OP_PRINTLN);
                    cnt_next = cnt_reg - 1'b1;
                end
                default: ;
            endcase
        end
        we = we && cmd.finish;
        wd = res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            if (cmd.finish) begin
                cnt_reg <= cnt_next;
                if (st_we) begin
                    store_reg[b_reg[SAW-1:0]] <= a_reg;
                end
            end
            if (cmd.finish) begin
                ovalid_reg <= 1'b1;
            end else if (out_taken) begin
                ovalid_reg <= 1'b0;
            end
        end
        if (cmd.capture) begin
            op_reg  <= in_op;
            imm_reg <= in_imm;
            tgt_reg <= in_tgt;
        end
        if (cmd.fetch) begin
            a_reg <= rd_a;
            b_reg <= rd_b;
        end
        mul_reg <= b_reg * a_reg;
        if (cmd.finish) begin
            o_print_valid <= pv;
            o_print_value <= pv ? a_reg : '0;
            o_newline     <= nl;
            o_jump_taken  <= jt;
            o_jump_index  <= jt ? smeu_pkg::TGT_W'(PW'(tgt_reg)) : '0;
            o_error       <= err;
            o_depth_now   <= smeu_pkg::DEPTH_W'(cnt_next);
        end
    end

    assign out_valid = ovalid_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish && err != smeu_pkg::ERR_NONE |=> cnt_reg == $past(cnt_reg))
        else $error("failed instruction changed depth");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !(we && st_we))
        else $error("stack and store written together");
endmodule

@@ design/stack_machine_execute_unit_core.sv @@
// Top level of the stack machine execute unit.
// Depends on smeu_pkg, smeu_ctrl and smeu_dp.
//
// One decoded instruction arrives per transfer on the s_ channel; exactly one
// result leaves per instruction on the m_ channel.
// s_axis_tdata (low bit up): op[4:0], immediate[36:5], target[48:37], zero fill.
// m_axis_tdata (low bit up): print_valid, print_value, newline, jump_taken,
//   jump_index, error, depth_now, zero fill to 64 bits.
// Sequence: an instruction passes through capture, stack read, decide and
// finish, and its result is offered from the result register after finish; pick
// adds a state for the second stack read, and div waits in a state for the
// one-bit-per-cycle divider to finish.
// The unit holds one instruction at a time: s_axis_tready is high only while idle.
// The result register holds its item while m_axis_tready is low; a finished
// instruction waits in the sequencer until that register is free, and the
// sequencer accepts the next transfer once it has committed.
// Reset (aresetn low, synchronous) empties the stack, zeroes the word store
// and drops any pending result. Stack contents are undefined until pushed.
module stack_machine_execute_unit_core #(
    parameter int STACK_DEPTH  = 64,
    parameter int STORE_DEPTH  = 8,
    parameter int PROGRAM_SPAN = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // op, immediate, target
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // print_valid, print_value, newline,
                                       // jump_taken, jump_index, error, depth_now
);
    smeu_pkg::cmd_t cmd;
    smeu_pkg::sts_t sts;
    logic in_ready, in_xfer, out_valid, out_taken, out_free;

    logic                         pv, nl, jt;
    logic [smeu_pkg::WORD_W-1:0]  pval;
    logic [smeu_pkg::TGT_W-1:0]   jidx;
    logic [smeu_pkg::ERR_W-1:0]   err;
    logic [smeu_pkg::DEPTH_W-1:0] dep;

    assign in_xfer   = s_axis_tvalid && in_ready;
    assign out_taken = out_valid && m_axis_tready;
    // Result register free: empty or being drained this cycle.
    assign out_free  = !out_valid || m_axis_tready;

    smeu_ctrl u_ctrl (.aclk, .aresetn, .in_xfer, .out_free, .sts, .in_ready, .cmd);

    smeu_dp #(.STACK_DEPTH(STACK_DEPTH), .STORE_DEPTH(STORE_DEPTH),
              .PROGRAM_SPAN(PROGRAM_SPAN)) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_op(s_axis_tdata[4:0]), .in_imm(s_axis_tdata[36:5]),
        .in_tgt(s_axis_tdata[48:37]),
        .out_taken, .out_valid,
        .o_print_valid(pv), .o_print_value(pval), .o_newline(nl),
        .o_jump_taken(jt), .o_jump_index(jidx), .o_error(err), .o_depth_now(dep));

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {7'd0, dep, err, jidx, jt, nl, pval, pv};

    assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_axis_tready)
        else $error("second transfer accepted while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> out_free)
        else $error("result register overwritten");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[63:57] == 7'd0)
        else $error("nonzero fill bit");
endmodule

@@ tb/sv/stack_machine_execute_unit_core_test.sv @@
// Testbench for stack_machine_execute_unit_core: directed and random instructions,
// each result checked against a local model of the operand stack and word store.
// Depends on smeu_pkg and the design top level only.
module stack_machine_execute_unit_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_SLOTS = 64;
    localparam int STORE_SLOTS = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] MOST_NEG = 32'h8000_0000;

    // Model of the unit: stack, word store and the queue of results owed.
    class exec_scoreboard;
        logic [31:0] stack_words [STACK_SLOTS];
        int unsigned depth;
        logic [31:0] store_words [STORE_SLOTS];
        logic [63:0] owed [$];
        int errors;

        function new();
            depth = 0;
            errors = 0;
            foreach (store_words[i]) store_words[i] = '0;
            foreach (stack_words[i]) stack_words[i] = '0;
        endfunction

        static function bit less_signed(logic [31:0] x, logic [31:0] y);
            return $signed(x) < $signed(y);
        endfunction

        static function logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
            logic [31:0] mn, md, q;
            mn = num[31] ? -num : num;
            md = den[31] ? -den : den;
            q = mn / md;
            return (num[31] != den[31]) ? -q : q;
        endfunction

        // Work out the result of one accepted instruction and advance the state.
        function void note(logic [4:0] op, logic [31:0] imm, logic [11:0] tgt);
            logic [31:0] a, b, r, k, idx, pval;
            logic pv, nl, jt;
            smeu_pkg::err_t err;
            int unsigned need, n;
            pv = 0; pval = '0; nl = 0; jt = 0; err = smeu_pkg::ERR_NONE; r = '0;
            n = depth;
            case (op)
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
                smeu_pkg::OP_EQ, smeu_pkg::OP_NE, smeu_pkg::OP_GT, smeu_pkg::OP_LT,
                smeu_pkg::OP_GE, smeu_pkg::OP_LE, smeu_pkg::OP_PICK,
                smeu_pkg::OP_MSET: need = 2;
                smeu_pkg::OP_NOT, smeu_pkg::OP_BRZ, smeu_pkg::OP_MGET, smeu_pkg::OP_PRINT,
                smeu_pkg::OP_PRINTLN: need = 1;
                default: need = 0;
            endcase
            if (n < need) begin
                err = smeu_pkg::ERR_UNDERFLOW;
            end else begin
                if (n >= 1) a = stack_words[n-1];
                if (n >= 2) b = stack_words[n-2];
                case (op)
                    smeu_pkg::OP_PUSH: begin
                        if (n >= STACK_SLOTS) err = smeu_pkg::ERR_OVERFLOW;
                        else begin
                            stack_words[n] = imm;
                            n++;
                        end
                    end
                    smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL, smeu_pkg::OP_DIV,
                    smeu_pkg::OP_EQ, smeu_pkg::OP_NE, smeu_pkg::OP_GT, smeu_pkg::OP_LT,
                    smeu_pkg::OP_GE, smeu_pkg::OP_LE: begin
                        case (op)
                            smeu_pkg::OP_ADD: r = b + a;
                            smeu_pkg::OP_SUB: r = b - a;
                            smeu_pkg::OP_MUL: r = b * a;
                            smeu_pkg::OP_DIV:
                                if (a == 0) err = smeu_pkg::ERR_DIVZERO;
                                else r = quotient(b, a);
                            smeu_pkg::OP_EQ:  r = (b == a);
                            smeu_pkg::OP_NE:  r = (b != a);
                            smeu_pkg::OP_GT:  r = less_signed(a, b);
                            smeu_pkg::OP_LT:  r = less_signed(b, a);
                            smeu_pkg::OP_GE:  r = !less_signed(b, a);
                            default: r = !less_signed(a, b);
                        endcase
                        if (err == smeu_pkg::ERR_NONE) begin
                            n--;
                            stack_words[n-1] = r;
                        end
                    end
                    smeu_pkg::OP_NOT: stack_words[n-1] = (a == 0);
                    smeu_pkg::OP_PICK: begin
                        k = a;
                        if (k[31] || k > n - 2) err = smeu_pkg::ERR_UNDERFLOW;
                        else stack_words[n-1] = stack_words[n-2-k];
                    end
                    smeu_pkg::OP_BRZ: begin
                        n--;
                        jt = (a == 0);
                    end
                    smeu_pkg::OP_JMP: jt = 1;
                    smeu_pkg::OP_MGET: begin
                        idx = a;
                        if (idx >= STORE_SLOTS) err = smeu_pkg::ERR_STORE;
                        else stack_words[n-1] = store_words[idx];
                    end
                    smeu_pkg::OP_MSET: begin
                        idx = b;
                        if (idx >= STORE_SLOTS) err = smeu_pkg::ERR_STORE;
                        else begin
                            store_words[idx] = a;
                            n -= 2;
                        end
                    end
                    smeu_pkg::OP_PRINT, smeu_pkg::OP_PRINTLN: begin
                        n--;
                        pv = 1;
                        pval = a;
                        nl = (op == smeu_pkg::OP_PRINTLN);
                    end
                    default: ;
                endcase
            end
            depth = n;
            owed.insert(owed.size(),
                {7'd0, 7'(n), 3'(err), jt ? tgt : 12'd0, jt, nl, pval, pv});
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        endtask

        // Compare one result transfer with the oldest result owed.
        task check(logic [63:0] data);
            logic [63:0] got, want;
            if (owed.size() == 0) begin
                report("unexpected result", data, '0);
                return;
            end
            got = data;
            want = owed.pop_front();
            if (got[0] !== want[0]) report("print_valid", got[0], want[0]);
            if (got[32:1] !== want[32:1]) report("print_value", got[32:1], want[32:1]);
            if (got[33] !== want[33]) report("newline", got[33], want[33]);
            if (got[34] !== want[34]) report("jump_taken", got[34], want[34]);
            if (got[46:35] !== want[46:35]) report("jump_index", got[46:35], want[46:35]);
            if (got[49:47] !== want[49:47]) report("error", got[49:47], want[49:47]);
            if (got[56:50] !== want[56:50]) report("depth_now", got[56:50], want[56:50]);
            if (got[63:57] !== want[63:57]) report("fill", got[63:57], want[63:57]);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    exec_scoreboard sb = new();
    int  cycles = 0;
    bit  calm = 0;      // set for a stretch with no idling on either side

    stack_machine_execute_unit_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Bound the run; a hang ends here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, then stall at random unless calm.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
        m_axis_tready <= aresetn && (calm || $urandom_range(0, 99) >= 21);
    end

    // Offer one instruction, optionally after an idle gap, and hold it until taken.
    task send(logic [4:0] op, logic [31:0] imm, logic [11:0] tgt);
        if (!calm && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, tgt, imm, op};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note(op, imm, tgt);
    endtask

    // Drop the offer and hold off until every owed result is back.
    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
    endtask

    // Operand value biased towards small numbers so that pick, store and
    // compare cases get hit, with extremes and full-width values mixed in.
    function logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 9);
            4: return MOST_NEG;
            5: return 32'h7FFF_FFFF;
            6: return 32'hFFFF_FFFF;
            7: return -$urandom_range(1, 9);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int push_pct;
        logic [4:0] op;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: underflow on empty, jump extremes, divide corner cases,
        // pick and store range errors, prints, branches and an undefined code.
        send(smeu_pkg::OP_ADD, '0, '0);
        send(smeu_pkg::OP_PRINT, '0, '0);
        send(smeu_pkg::OP_JMP, '0, 12'hFFF);
        send(smeu_pkg::OP_PUSH, MOST_NEG, '0);
        send(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF, '0);
        send(smeu_pkg::OP_DIV, '0, '0);
        send(smeu_pkg::OP_PUSH, '0, '0);
        send(smeu_pkg::OP_DIV, '0, '0);
        send(smeu_pkg::OP_NOT, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'h7FFF_FFFF, '0);
        send(smeu_pkg::OP_PUSH, 32'd5, '0);
        send(smeu_pkg::OP_PICK, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'hFFFF_FFFF, '0);
        send(smeu_pkg::OP_PICK, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'd8, '0);
        send(smeu_pkg::OP_MGET, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'd42, '0);
        send(smeu_pkg::OP_MSET, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'd7, '0);
        send(smeu_pkg::OP_PUSH, 32'hA5A5_5A5A, '0);
        send(smeu_pkg::OP_MSET, '0, '0);
        send(smeu_pkg::OP_PUSH, 32'd7, '0);
        send(smeu_pkg::OP_MGET, '0, '0);
        send(smeu_pkg::OP_PRINTLN, '0, '0);
        send(smeu_pkg::OP_BRZ, '0, 12'h5A5);
        send(5'd31, '0, '0);
        drain();

        // Random: push bias changes every so often so the stack both fills to
        // overflow and empties to underflow.
        push_pct = 40;
        for (int i = 0; i < 1000; i++) begin
            if (i % 60 == 0) push_pct = $urandom_range(20, 75);
            calm = (i >= 400 && i < 550);
            if (i == 700) drain();   // hold off until every result is back
            if ($urandom_range(0, 99) < push_pct) op = smeu_pkg::OP_PUSH;
            else if ($urandom_range(0, 49) == 0) op = $urandom_range(19, 31);
            else op = $urandom_range(1, 18);
            send(op, ($urandom_range(0, 3) == 0) ? $urandom : pick_value(),
                 $urandom_range(0, 4095));
        end
        calm = 0;
        s_axis_tvalid <= 1'b0;
        drain();
        repeat (100) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
